// ===== rtl/hsv565_pkg.sv =====
// Shared types and constants for the HSV to RGB565 conversion pipeline.
`timescale 1ns / 1ps

package hsv565_pkg;

  // Field widths.
  localparam int HueW   = 9;
  localparam int PctW   = 7;
  localparam int ChanW  = 8;
  localparam int PackW  = 16;
  localparam int RegionW = 3;

  // Input ranges and the full 8-bit scale.
  localparam logic [HueW-1:0]  HueMax  = HueW'(359);
  localparam logic [PctW-1:0]  PctMax  = PctW'(100);
  localparam int               FullScale = 255;

  // Six-sector bounds on the 8-bit hue (multiples of the sector width 43).
  localparam logic [ChanW-1:0] SectorW = ChanW'(43);
  localparam logic [ChanW-1:0] Bound1  = ChanW'(43);
  localparam logic [ChanW-1:0] Bound2  = ChanW'(86);
  localparam logic [ChanW-1:0] Bound3  = ChanW'(129);
  localparam logic [ChanW-1:0] Bound4  = ChanW'(172);
  localparam logic [ChanW-1:0] Bound5  = ChanW'(215);

  // Sector codes.
  localparam logic [RegionW-1:0] SecRedYel = RegionW'(0);
  localparam logic [RegionW-1:0] SecYelGrn = RegionW'(1);
  localparam logic [RegionW-1:0] SecGrnCyn = RegionW'(2);
  localparam logic [RegionW-1:0] SecCynBlu = RegionW'(3);
  localparam logic [RegionW-1:0] SecBluMag = RegionW'(4);
  localparam logic [RegionW-1:0] SecMagRed = RegionW'(5);

  // Truncating rescale x*255/top done as (x*recip) >> shift. The rounding-up
  // reciprocal is exact here because x*(recip*top - 255*2^shift) < 2^shift
  // over the whole clamped input range.
  localparam int RecipW   = 18;
  localparam int HueShift = 18;
  localparam int PctShift = 16;
  localparam logic [RecipW-1:0] HueRecip =
    RecipW'((FullScale * (2 ** HueShift) + 358) / 359);
  localparam logic [RecipW-1:0] PctRecip =
    RecipW'((FullScale * (2 ** PctShift) + 99) / 100);

  // RGB565 packing: floor(c*31/255) and floor(c*63/255) by reciprocal.
  localparam int PackShift = 16;
  localparam int PackRecipW = 14;
  localparam logic [PackRecipW-1:0] R5Recip =
    PackRecipW'((31 * (2 ** PackShift) + 254) / FullScale);
  localparam logic [PackRecipW-1:0] G6Recip =
    PackRecipW'((63 * (2 ** PackShift) + 254) / FullScale);

  // Pipeline step control handed to a stage module.
  typedef struct packed {
    logic en;   // stages advance this cycle
    logic vld;  // the item entering the stage is real
  } pipe_ctl_t;

endpackage

// ===== rtl/hsv565_if.sv =====
// Request channel interfaces: HSV request in, RGB/RGB565 request out.
`timescale 1ns / 1ps

interface hsv565_in_if import hsv565_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue_deg;
  logic [PctW-1:0] sat_pct;
  logic [PctW-1:0] val_pct;

  modport source (output valid, hue_deg, sat_pct, val_pct, input ready);
  modport sink   (input valid, hue_deg, sat_pct, val_pct, output ready);
endinterface

interface hsv565_out_if import hsv565_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic [PackW-1:0] packed_565;

  modport source (output valid, red_out, green_out, blue_out, packed_565, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, packed_565, output ready);
endinterface

// ===== rtl/hsv565_scale.sv =====
// Stage 1: clamp hue, saturation and value and rescale each to 0..255.
`timescale 1ns / 1ps

module hsv565_scale import hsv565_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctl_t        ctl,
  input  logic [HueW-1:0]  hue_deg,
  input  logic [PctW-1:0]  sat_pct,
  input  logic [PctW-1:0]  val_pct,
  output logic             vld_r,
  output logic [ChanW-1:0] h8_r,
  output logic [ChanW-1:0] s8_r,
  output logic [ChanW-1:0] v8_r
);

  logic [HueW-1:0]         hue_c;
  logic [PctW-1:0]         sat_c;
  logic [PctW-1:0]         val_c;
  logic [HueW+RecipW-1:0]  hue_prod;
  logic [PctW+RecipW-1:0]  sat_prod;
  logic [PctW+RecipW-1:0]  val_prod;

  // Clamp out-of-range requests to the top of their range.
  assign hue_c = (hue_deg > HueMax) ? HueMax : hue_deg;
  assign sat_c = (sat_pct > PctMax) ? PctMax : sat_pct;
  assign val_c = (val_pct > PctMax) ? PctMax : val_pct;

  // Reciprocal multiplies; the shift picks the truncated quotient.
  assign hue_prod = (HueW+RecipW)'(hue_c) * (HueW+RecipW)'(HueRecip);
  assign sat_prod = (PctW+RecipW)'(sat_c) * (PctW+RecipW)'(PctRecip);
  assign val_prod = (PctW+RecipW)'(val_c) * (PctW+RecipW)'(PctRecip);

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= ctl.vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      h8_r <= hue_prod[HueShift +: ChanW];
      s8_r <= sat_prod[PctShift +: ChanW];
      v8_r <= val_prod[PctShift +: ChanW];
    end
  end

endmodule

// ===== rtl/hsv565_pack.sv =====
// Final stage: RGB565 packing and the output register.
`timescale 1ns / 1ps

module hsv565_pack import hsv565_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctl_t        ctl,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             vld_r,
  output logic [ChanW-1:0] red_r,
  output logic [ChanW-1:0] green_r,
  output logic [ChanW-1:0] blue_r,
  output logic [PackW-1:0] packed_r
);

  localparam int ProdW = ChanW + PackRecipW;

  logic [ProdW-1:0] r_prod;
  logic [ProdW-1:0] g_prod;
  logic [ProdW-1:0] b_prod;
  logic [PackW-1:0] packed_nxt;

  // floor(c*31/255) and floor(c*63/255) through exact reciprocals.
  assign r_prod = ProdW'(red)   * ProdW'(R5Recip);
  assign g_prod = ProdW'(green) * ProdW'(G6Recip);
  assign b_prod = ProdW'(blue)  * ProdW'(R5Recip);

  assign packed_nxt = {r_prod[PackShift +: 5], g_prod[PackShift +: 6],
                       b_prod[PackShift +: 5]};

  // Valid bit of the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= ctl.vld;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      red_r    <= red;
      green_r  <= green;
      blue_r   <= blue;
      packed_r <= packed_nxt;
    end
  end

endmodule

// ===== rtl/hsv_to_rgb565_unit.sv =====
// Top level: five-stage HSV to RGB and RGB565 conversion pipeline.
//
//   channel   direction  payload                                     handshake
//   in_hsv    sink       hue_deg[8:0] sat_pct[6:0] val_pct[6:0]      valid/ready
//   out_rgb   source     red_out green_out blue_out [7:0]            valid/ready
//                        packed_565[15:0]
//
// One request per clock while no result waits unread; each result is offered
// once its request has passed five register stages (rescale, sector and
// products, p/q/t, channel select, pack).
// All five stages advance together whenever the output register is empty or
// being drained, so in_hsv.ready is low only while a result waits unread.
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
`timescale 1ns / 1ps

module hsv_to_rgb565_unit import hsv565_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  hsv565_in_if.sink    in_hsv,
  hsv565_out_if.source out_rgb
);

  pipe_ctl_t        ctl1;
  pipe_ctl_t        ctl5;
  logic             adv;
  logic             out_vld;

  // Stage 1 outputs.
  logic             s1_vld;
  logic [ChanW-1:0] s1_h8;
  logic [ChanW-1:0] s1_s8;
  logic [ChanW-1:0] s1_v8;

  // Stage 2 registers.
  logic               s2_vld_r;
  logic [ChanW-1:0]   s2_v8_r;
  logic [ChanW-1:0]   s2_s8_r;
  logic               s2_grey_r;
  logic [RegionW-1:0] s2_region_r;
  logic [ChanW-1:0]   s2_sa_r;
  logic [ChanW-1:0]   s2_sb_r;

  // Stage 3 registers.
  logic               s3_vld_r;
  logic [ChanW-1:0]   s3_v8_r;
  logic               s3_grey_r;
  logic [RegionW-1:0] s3_region_r;
  logic [ChanW-1:0]   s3_p_r;
  logic [ChanW-1:0]   s3_q_r;
  logic [ChanW-1:0]   s3_t_r;

  // Stage 4 registers.
  logic               s4_vld_r;
  logic [ChanW-1:0]   s4_red_r;
  logic [ChanW-1:0]   s4_green_r;
  logic [ChanW-1:0]   s4_blue_r;

  // Combinational values.
  logic [RegionW-1:0] region_nxt;
  logic [ChanW-1:0]   base;
  logic [ChanW-1:0]   offset;
  logic [ChanW-1:0]   rem_nxt;
  logic [ChanW-1:0]   rem_cmp;
  logic [ChanW-1:0]   s_cmp;
  logic [ChanW-1:0]   sa_cmp;
  logic [ChanW-1:0]   sb_cmp;
  logic [2*ChanW-1:0] sa_prod;
  logic [2*ChanW-1:0] sb_prod;
  logic [2*ChanW-1:0] p_prod;
  logic [2*ChanW-1:0] q_prod;
  logic [2*ChanW-1:0] t_prod;
  logic [ChanW-1:0]   red_nxt;
  logic [ChanW-1:0]   green_nxt;
  logic [ChanW-1:0]   blue_nxt;

  // Whole-pipe advance: the output register is free or is being read.
  assign adv          = !out_vld || out_rgb.ready;
  assign in_hsv.ready = adv;
  assign ctl1         = '{en: adv, vld: in_hsv.valid};
  assign ctl5         = '{en: adv, vld: s4_vld_r};

  // Stage 1: clamp and rescale.
  hsv565_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl1),
    .hue_deg (in_hsv.hue_deg),
    .sat_pct (in_hsv.sat_pct),
    .val_pct (in_hsv.val_pct),
    .vld_r   (s1_vld),
    .h8_r    (s1_h8),
    .s8_r    (s1_s8),
    .v8_r    (s1_v8)
  );

  // Stage 2: sector index, scaled remainder and the saturation products.
  always_comb begin
    if (s1_h8 >= Bound5) begin
      region_nxt = SecMagRed;
      base       = Bound5;
    end else if (s1_h8 >= Bound4) begin
      region_nxt = SecBluMag;
      base       = Bound4;
    end else if (s1_h8 >= Bound3) begin
      region_nxt = SecCynBlu;
      base       = Bound3;
    end else if (s1_h8 >= Bound2) begin
      region_nxt = SecGrnCyn;
      base       = Bound2;
    end else if (s1_h8 >= Bound1) begin
      region_nxt = SecYelGrn;
      base       = Bound1;
    end else begin
      region_nxt = SecRedYel;
      base       = '0;
    end
  end

  // The offset within a sector stays below 43, so six times it fits 8 bits.
  assign offset  = s1_h8 - base;
  assign rem_nxt = ChanW'({offset, 2'b00} + {offset, 1'b0});
  // 255 - x on an 8-bit value is its bitwise inverse.
  assign rem_cmp = ~rem_nxt;
  assign sa_prod = (2*ChanW)'(s1_s8) * (2*ChanW)'(rem_nxt);
  assign sb_prod = (2*ChanW)'(s1_s8) * (2*ChanW)'(rem_cmp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_v8_r     <= s1_v8;
      s2_s8_r     <= s1_s8;
      s2_grey_r   <= (s1_s8 == '0);
      s2_region_r <= region_nxt;
      s2_sa_r     <= sa_prod[ChanW +: ChanW];
      s2_sb_r     <= sb_prod[ChanW +: ChanW];
    end
  end

  // Stage 3: p, q and t as value times the complemented factors.
  assign s_cmp  = ~s2_s8_r;
  assign sa_cmp = ~s2_sa_r;
  assign sb_cmp = ~s2_sb_r;
  assign p_prod = (2*ChanW)'(s2_v8_r) * (2*ChanW)'(s_cmp);
  assign q_prod = (2*ChanW)'(s2_v8_r) * (2*ChanW)'(sa_cmp);
  assign t_prod = (2*ChanW)'(s2_v8_r) * (2*ChanW)'(sb_cmp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_v8_r     <= s2_v8_r;
      s3_grey_r   <= s2_grey_r;
      s3_region_r <= s2_region_r;
      s3_p_r      <= p_prod[ChanW +: ChanW];
      s3_q_r      <= q_prod[ChanW +: ChanW];
      s3_t_r      <= t_prod[ChanW +: ChanW];
    end
  end

  // Stage 4: pick the channels by sector; zero saturation gives grey.
  always_comb begin
    unique case (s3_region_r)
      SecRedYel: begin
        red_nxt = s3_v8_r; green_nxt = s3_t_r;  blue_nxt = s3_p_r;
      end
      SecYelGrn: begin
        red_nxt = s3_q_r;  green_nxt = s3_v8_r; blue_nxt = s3_p_r;
      end
      SecGrnCyn: begin
        red_nxt = s3_p_r;  green_nxt = s3_v8_r; blue_nxt = s3_t_r;
      end
      SecCynBlu: begin
        red_nxt = s3_p_r;  green_nxt = s3_q_r;  blue_nxt = s3_v8_r;
      end
      SecBluMag: begin
        red_nxt = s3_t_r;  green_nxt = s3_p_r;  blue_nxt = s3_v8_r;
      end
      default: begin
        red_nxt = s3_v8_r; green_nxt = s3_p_r;  blue_nxt = s3_q_r;
      end
    endcase
    if (s3_grey_r) begin
      red_nxt   = s3_v8_r;
      green_nxt = s3_v8_r;
      blue_nxt  = s3_v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_red_r   <= red_nxt;
      s4_green_r <= green_nxt;
      s4_blue_r  <= blue_nxt;
    end
  end

  // Stage 5: RGB565 packing into the output register.
  hsv565_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl5),
    .red      (s4_red_r),
    .green    (s4_green_r),
    .blue     (s4_blue_r),
    .vld_r    (out_vld),
    .red_r    (out_rgb.red_out),
    .green_r  (out_rgb.green_out),
    .blue_r   (out_rgb.blue_out),
    .packed_r (out_rgb.packed_565)
  );

  assign out_rgb.valid = out_vld;

endmodule

// ===== rtl/hsv565_checker.sv =====
// Port-level checker for the conversion unit and its bind to the top level.
`timescale 1ns / 1ps

module hsv565_sva import hsv565_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ChanW-1:0] red_out,
  input logic [ChanW-1:0] green_out,
  input logic [ChanW-1:0] blue_out,
  input logic [PackW-1:0] packed_565
);

  // A result waiting unread stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(packed_565) && $stable(red_out))
    else $error("stalled result payload changed");

  // The pipe only stalls its input when a result waits unread.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with the output free");

  // The packed fields never exceed the top bits of the 8-bit channels.
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> packed_565[15:11] <= red_out[7:3] &&
                  packed_565[10:5]  <= green_out[7:2] &&
                  packed_565[4:0]   <= blue_out[7:3])
    else $error("packed word out of line with the channels");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind hsv_to_rgb565_unit hsv565_sva u_hsv565_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_hsv.ready),
  .out_valid  (out_rgb.valid),
  .out_ready  (out_rgb.ready),
  .red_out    (out_rgb.red_out),
  .green_out  (out_rgb.green_out),
  .blue_out   (out_rgb.blue_out),
  .packed_565 (out_rgb.packed_565)
);

// ===== test/hsv565_checker.sv =====
// Scoreboard for the HSV to RGB565 unit: predicts each request's color and compares results.
`timescale 1ns / 1ps

module hsv565_checker import hsv565_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hsv565_in_if        hsv_req,
  hsv565_out_if       rgb_req,
  output int unsigned mismatch_count,
  output int unsigned colors_pending
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [PackW-1:0] word565;
  } rgb_color_t;

  rgb_color_t  color_q[$];
  int unsigned fail_tally = 0;
  int unsigned pending_n = 0;

  assign mismatch_count = fail_tally;
  assign colors_pending = pending_n;

  // Truncating rescale of a clamped field onto 0..255.
  function automatic logic [ChanW-1:0] scale_to_byte(input int unsigned x,
                                                      input int unsigned top);
    int unsigned xc;
    xc = (x > top) ? top : x;
    return ChanW'((xc * FullScale) / top);
  endfunction

  // Six-sector integer HSV to RGB, followed by the 565 packing.
  function automatic rgb_color_t convert_hsv(input logic [HueW-1:0] hue,
                                             input logic [PctW-1:0] sat,
                                             input logic [PctW-1:0] val);
    logic [ChanW-1:0]   h8, s8, v8, rem, p, q, t;
    logic [RegionW-1:0] region;
    int unsigned        sector_w;
    rgb_color_t         c;
    h8 = scale_to_byte(int'(hue), int'(HueMax));
    s8 = scale_to_byte(int'(sat), int'(PctMax));
    v8 = scale_to_byte(int'(val), int'(PctMax));
    sector_w = int'(SectorW);
    region = RegionW'(int'(h8) / sector_w);
    rem = ChanW'((int'(h8) - int'(region) * sector_w) * 6);
    p = ChanW'((int'(v8) * (FullScale - int'(s8))) >> 8);
    q = ChanW'((int'(v8) * (FullScale - ((int'(s8) * int'(rem)) >> 8))) >> 8);
    t = ChanW'((int'(v8) * (FullScale - ((int'(s8) * (FullScale - int'(rem))) >> 8))) >> 8);
    if (s8 == '0) begin
      c.red = v8;
      c.green = v8;
      c.blue = v8;
    end else begin
      case (region)
        SecRedYel: begin c.red = v8; c.green = t;  c.blue = p;  end
        SecYelGrn: begin c.red = q;  c.green = v8; c.blue = p;  end
        SecGrnCyn: begin c.red = p;  c.green = v8; c.blue = t;  end
        SecCynBlu: begin c.red = p;  c.green = q;  c.blue = v8; end
        SecBluMag: begin c.red = t;  c.green = p;  c.blue = v8; end
        default:   begin c.red = v8; c.green = p;  c.blue = q;  end
      endcase
    end
    c.word565 = {5'((int'(c.red) * 31) / FullScale),
                 6'((int'(c.green) * 63) / FullScale),
                 5'((int'(c.blue) * 31) / FullScale)};
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_tally++;
    end
  endtask

  // Compare each delivered color with the oldest prediction, then queue new requests.
  always @(posedge clk) begin : scoreboard
    rgb_color_t want;
    if (rst_n) begin
      if (rgb_req.valid && rgb_req.ready) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d w=%h",
                   $time, rgb_req.red_out, rgb_req.green_out, rgb_req.blue_out,
                   rgb_req.packed_565);
          fail_tally++;
        end else begin
          want = color_q.pop_front();
          check_field("red_out", want.red, rgb_req.red_out);
          check_field("green_out", want.green, rgb_req.green_out);
          check_field("blue_out", want.blue, rgb_req.blue_out);
          check_field("packed_565", want.word565, rgb_req.packed_565);
        end
      end
      if (hsv_req.valid && hsv_req.ready) begin
        color_q.push_back(convert_hsv(hsv_req.hue_deg, hsv_req.sat_pct, hsv_req.val_pct));
      end
    end
    pending_n <= color_q.size();
  end

endmodule

// ===== test/tb_hsv_to_rgb565_unit.sv =====
// Top-level testbench for the HSV to RGB565 unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_hsv_to_rgb565_unit;
  import hsv565_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 300;
  localparam int PhaseItems = 300;
  localparam int DrainWait  = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned colors_pending;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned hold_len = 0;

  hsv565_in_if  in_hsv ();
  hsv565_out_if out_rgb ();

  hsv_to_rgb565_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_hsv  (in_hsv),
    .out_rgb (out_rgb)
  );

  hsv565_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .hsv_req        (in_hsv),
    .rgb_req        (out_rgb),
    .mismatch_count (mismatch_count),
    .colors_pending (colors_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("hsv_to_rgb565_unit test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off during the pressure phase.
  initial begin
    out_rgb.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_on && hold_len < LongHold) begin
        out_rgb.ready <= 1'b0;
        hold_len++;
      end else begin
        out_rgb.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request after a random gap and wait for it to be taken.
  task automatic send_hsv(input logic [HueW-1:0] h, input logic [PctW-1:0] s,
                          input logic [PctW-1:0] v);
    while ($urandom_range(99) < gap_pct) begin
      in_hsv.valid <= 1'b0;
      @(posedge clk);
    end
    in_hsv.valid   <= 1'b1;
    in_hsv.hue_deg <= h;
    in_hsv.sat_pct <= s;
    in_hsv.val_pct <= v;
    @(posedge clk);
    while (!in_hsv.ready) @(posedge clk);
  endtask

  // Mostly in-range colors, some grey, some with every field bit free.
  task automatic send_random(input int unsigned count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_hsv(HueW'($urandom_range(511)), PctW'($urandom_range(127)),
                 PctW'($urandom_range(127)));
      end else if (pick < 25) begin
        send_hsv(HueW'($urandom_range(359)), '0, PctW'($urandom_range(100)));
      end else begin
        send_hsv(HueW'($urandom_range(359)), PctW'($urandom_range(100)),
                 PctW'($urandom_range(100)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_hsv.valid = 1'b0;
    in_hsv.hue_deg = '0;
    in_hsv.sat_pct = '0;
    in_hsv.val_pct = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed colors: extremes, clamping, grey, and a hue in each sector.
    send_hsv(9'd0, 7'd0, 7'd0);
    send_hsv(9'd359, 7'd100, 7'd100);
    send_hsv(9'd511, 7'd127, 7'd127);
    send_hsv(9'd360, 7'd101, 7'd101);
    send_hsv(9'd200, 7'd0, 7'd77);
    send_hsv(9'd200, 7'd0, 7'd127);
    send_hsv(9'd100, 7'd1, 7'd100);
    send_hsv(9'd100, 7'd100, 7'd0);
    send_hsv(9'd0, 7'd100, 7'd100);
    send_hsv(9'd30, 7'd100, 7'd100);
    send_hsv(9'd61, 7'd100, 7'd100);
    send_hsv(9'd90, 7'd80, 7'd90);
    send_hsv(9'd122, 7'd100, 7'd100);
    send_hsv(9'd150, 7'd60, 7'd70);
    send_hsv(9'd182, 7'd100, 7'd100);
    send_hsv(9'd210, 7'd50, 7'd100);
    send_hsv(9'd243, 7'd100, 7'd100);
    send_hsv(9'd270, 7'd90, 7'd40);
    send_hsv(9'd303, 7'd100, 7'd100);
    send_hsv(9'd330, 7'd75, 7'd100);
    send_hsv(9'd358, 7'd100, 7'd50);
    send_hsv(9'd256, 7'd64, 7'd64);

    // Random colors under the idling phases.
    send_random(PhaseItems);
    gap_pct = 86;
    send_random(PhaseItems);
    gap_pct = 0;
    stall_pct <= 86;
    send_random(PhaseItems);
    gap_pct = 29;
    stall_pct <= 29;
    send_random(PhaseItems);

    // Back-pressure: the receiver holds off while requests keep coming.
    gap_pct = 0;
    stall_pct <= 0;
    hold_on <= 1'b1;
    send_random(60);
    in_hsv.valid <= 1'b0;

    @(posedge clk);
    while (colors_pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hsv_to_rgb565_unit test passed");
    end else begin
      $display("hsv_to_rgb565_unit test failed");
    end
    $finish;
  end

endmodule
